// ===== design/ebts_pkg.sv =====
// ----------------------------------------------------------------------------
// ebts_pkg: shared types, constants and helpers
// Item and result layouts, access codes and address-register encoding for the
// byte transfer sequencer.
// ----------------------------------------------------------------------------
package ebts_pkg;

  // Width kept for the transfer byte count
  localparam int unsigned LenBits = 16;

  // Port offsets from the I/O base
  localparam logic [15:0] AddrLoOffs = 16'd2;
  localparam logic [15:0] AddrHiOffs = 16'd3;
  localparam logic [15:0] DataOffs   = 16'd4;

  // Address register encoding
  localparam logic [7:0] LoAddrMask = 8'hfc;
  localparam logic [7:0] HiAddrMask = 8'h7f;
  localparam logic [7:0] ModeByte   = 8'h00;
  localparam logic [7:0] ModeAuto   = 8'h03;
  localparam logic [1:0] LaneMask   = 2'h3;
  localparam logic [1:0] LaneLast   = 2'd3;
  localparam logic [LenBits-1:0] AutoMinLen = LenBits'(4);

  // Results per item at most
  localparam logic [1:0] GrpMax = 2'd3;

  // Config register byte address bit that selects the register index
  localparam int unsigned CfgAddrBits = 3;
  localparam logic RegIoBase = 1'b0;

  typedef enum logic {
    CmdStart = 1'b0,
    CmdByte  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KindAddr = 2'd0,
    KindData = 2'd1,
    KindDone = 2'd2
  } kind_e;

  typedef struct packed {
    logic        cmd;
    logic        is_write;
    logic [15:0] start_offset;
    logic [15:0] length;
    logic [7:0]  byte_value;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] port;
    logic        wr;
    logic [7:0]  value;
    logic        last;
    logic        done;
    logic [7:0]  sum;
  } res_t;

  // Group of results caused by one item
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      res;
  } grp_t;

  // Low address register write: offset bits 7:2 plus mode
  function automatic res_t addr_lo(logic [15:0] base, logic [15:0] off, logic autoinc);
    res_t r;
    r       = '0;
    r.kind  = KindAddr;
    r.port  = base + AddrLoOffs;
    r.wr    = 1'b1;
    r.value = (off[7:0] & LoAddrMask) | (autoinc ? ModeAuto : ModeByte);
    return r;
  endfunction

  // High address register write: offset bits 14:8, closes the pair
  function automatic res_t addr_hi(logic [15:0] base, logic [15:0] off);
    res_t r;
    r       = '0;
    r.kind  = KindAddr;
    r.port  = base + AddrHiOffs;
    r.wr    = 1'b1;
    r.value = off[15:8] & HiAddrMask;
    r.last  = 1'b1;
    return r;
  endfunction

endpackage

// ===== design/ebts_core.sv =====
// ----------------------------------------------------------------------------
// ebts_core: transfer state and per-item step
// Holds the transfer state and turns one registered item into its group of
// up to three results combinationally.
// ----------------------------------------------------------------------------
module ebts_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ebts_pkg::item_t item_i,
  input  logic            proc_i,
  input  logic [15:0]     io_base_i,
  output ebts_pkg::grp_t  grp_o
);
  import ebts_pkg::*;

  logic               busy_q, busy_d;
  logic [LenBits-1:0] left_q, left_d;
  logic [15:0]        off_q, off_d;
  logic [1:0]         lane_q, lane_d;
  logic               auto_q, auto_d;
  logic               dir_q, dir_d;
  logic [7:0]         sum_q, sum_d;

  logic [LenBits-1:0] len;
  logic [LenBits-1:0] left_dec;
  logic [15:0]        off_inc;
  logic [7:0]         sum_inc;
  logic [15:0]        lane_port;
  logic               start_auto;
  logic               next_auto;
  res_t               data_res;

  assign len        = LenBits'(item_i.length);
  assign left_dec   = left_q - LenBits'(1);
  assign off_inc    = off_q + 16'd1;
  assign sum_inc    = sum_q + item_i.byte_value;
  assign lane_port  = io_base_i + DataOffs + 16'(lane_q);
  assign start_auto = ((item_i.start_offset[1:0] & LaneMask) == 2'd0) && (len >= AutoMinLen);
  assign next_auto  = !((left_dec < AutoMinLen) && dir_q);

  // Data lane access for a byte item
  always_comb begin
    data_res       = '0;
    data_res.kind  = KindData;
    data_res.port  = lane_port;
    data_res.wr    = dir_q;
    data_res.value = item_i.byte_value;
  end

  // Step: next state and result group
  always_comb begin
    busy_d = busy_q;
    left_d = left_q;
    off_d  = off_q;
    lane_d = lane_q;
    auto_d = auto_q;
    dir_d  = dir_q;
    sum_d  = sum_q;
    grp_o  = '0;

    if (item_i.cmd == CmdStart) begin
      busy_d = 1'b0;
      sum_d  = '0;
      if (io_base_i == 16'd0 || len == '0) begin
        // Empty transfer or unset I/O base: completion only
        left_d              = '0;
        grp_o.cnt           = 2'd1;
        grp_o.res[0].kind   = KindDone;
        grp_o.res[0].last   = 1'b1;
        grp_o.res[0].done   = 1'b1;
      end else begin
        busy_d       = 1'b1;
        dir_d        = item_i.is_write;
        left_d       = len;
        off_d        = item_i.start_offset;
        lane_d       = item_i.start_offset[1:0] & LaneMask;
        auto_d       = start_auto;
        grp_o.cnt    = 2'd2;
        grp_o.res[0] = addr_lo(io_base_i, item_i.start_offset, start_auto);
        grp_o.res[1] = addr_hi(io_base_i, item_i.start_offset);
      end
    end else if (busy_q) begin
      sum_d        = sum_inc;
      off_d        = off_inc;
      left_d       = left_dec;
      grp_o.cnt    = 2'd1;
      grp_o.res[0] = data_res;
      if (left_dec == '0) begin
        // Final byte reports the checksum
        busy_d            = 1'b0;
        grp_o.res[0].last = 1'b1;
        grp_o.res[0].done = 1'b1;
        grp_o.res[0].sum  = sum_inc;
      end else if (lane_q != LaneLast) begin
        lane_d            = lane_q + 2'd1;
        grp_o.res[0].last = 1'b1;
      end else begin
        lane_d = 2'd0;
        if (next_auto != auto_q || !auto_q) begin
          // Word boundary with a mode rewrite
          auto_d       = next_auto;
          grp_o.cnt    = GrpMax;
          grp_o.res[1] = addr_lo(io_base_i, off_inc, next_auto);
          grp_o.res[2] = addr_hi(io_base_i, off_inc);
        end else begin
          grp_o.res[0].last = 1'b1;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      left_q <= '0;
      off_q  <= '0;
      lane_q <= '0;
      auto_q <= 1'b0;
      dir_q  <= 1'b0;
      sum_q  <= '0;
    end else if (proc_i) begin
      busy_q <= busy_d;
      left_q <= left_d;
      off_q  <= off_d;
      lane_q <= lane_d;
      auto_q <= auto_d;
      dir_q  <= dir_d;
      sum_q  <= sum_d;
    end
  end

endmodule

// ===== design/ebts_outq.sv =====
// ----------------------------------------------------------------------------
// ebts_outq: result group buffer
// Holds the results of one item and hands them out one per cycle unless
// stalled; frees itself for the next group as the last result is taken.
// ----------------------------------------------------------------------------
module ebts_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ebts_pkg::grp_t grp_i,
  input  logic           load_i,
  input  logic           out_stall_i,
  output logic           free_o,
  output logic           out_valid_o,
  output ebts_pkg::res_t res_o
);
  import ebts_pkg::*;

  res_t [2:0] ent_q;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       take;

  assign out_valid_o = (cnt_q != 2'd0);
  assign take        = out_valid_o && !out_stall_i;
  assign free_o      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !out_stall_i);
  assign res_o       = ent_q[idx_q];

  // Count and read pointer
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = grp_i.cnt;
      idx_d = 2'd0;
    end else if (take) begin
      cnt_d = cnt_q - 2'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= grp_i.res;
    end
  end

endmodule

// ===== design/emi_byte_transfer_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// emi_byte_transfer_sequencer_unit: byte transfer sequencer top level
// Turns start and byte items into address-register writes, data-lane
// accesses and completion reports for an embedded-memory interface.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item per handshake: a
//   start item (cmd 0) or a data byte (cmd 1). Output channel (out_valid_o /
//   out_stall_i) delivers results one per cycle, run_last_o marking the last
//   result of an item. io_base is set over the APB port while idle.
//   An accepted item is held in the input register and stepped into the
//   result buffer when the buffer is free; its first result shows on the
//   output as soon as the group is in the buffer.
//   Results leave the buffer one at a time through the single output
//   port, one to three per item; byte items on an idle engine give none.
//   The next item is taken while the buffer drains.
//   Reset clears the transfer state, io_base and both buffers; the block is
//   ready as soon as reset is released. When the receiver stalls, the
//   result holds, the buffer fills and in_stall_o rises with an item held.
// ----------------------------------------------------------------------------
module emi_byte_transfer_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic                          is_write_i,
  input  logic [15:0]                   start_offset_i,
  input  logic [15:0]                   length_i,
  input  logic [7:0]                    byte_value_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [15:0]                   port_o,
  output logic                          write_access_o,
  output logic [7:0]                    value_o,
  output logic                          run_last_o,
  output logic                          transfer_done_o,
  output logic [7:0]                    checksum_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ebts_pkg::CfgAddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ebts_pkg::*;

  item_t       in_q;
  logic        in_vld_q;
  logic [15:0] io_base_q;
  logic        free;
  logic        proc;
  logic        in_acc;
  grp_t        grp;
  res_t        res;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[CfgAddrBits-1] == RegIoBase) ? {16'd0, io_base_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      io_base_q <= '0;
    end else if (psel && penable && pwrite && paddr[CfgAddrBits-1] == RegIoBase) begin
      io_base_q <= pwdata[15:0];
    end
  end

  // Input register
  assign proc       = in_vld_q && free;
  assign in_stall_o = in_vld_q && !free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q.cmd          <= cmd_i;
      in_q.is_write     <= is_write_i;
      in_q.start_offset <= start_offset_i;
      in_q.length       <= length_i;
      in_q.byte_value   <= byte_value_i;
    end
  end

  // Step logic and result buffer
  ebts_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (in_q),
    .proc_i    (proc),
    .io_base_i (io_base_q),
    .grp_o     (grp)
  );

  ebts_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (grp),
    .load_i      (proc),
    .out_stall_i (out_stall_i),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign kind_o          = res.kind;
  assign port_o          = res.port;
  assign write_access_o  = res.wr;
  assign value_o         = res.value;
  assign run_last_o      = res.last;
  assign transfer_done_o = res.done;
  assign checksum_o      = res.sum;

  // A stepped item with results shows a result in the next cycle
  a_group_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && grp.cnt != 2'd0 |=> out_valid_o)
    else $error("result group not presented");

  // Transfer end always closes the item's run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && transfer_done_o |-> run_last_o)
    else $error("transfer end without run end");

  // Completion-only result carries no checksum and ends the transfer
  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindDone |-> transfer_done_o && checksum_o == 8'd0)
    else $error("bad completion result");

  // Address register accesses are writes
  a_addr_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindAddr |-> write_access_o)
    else $error("address access not a write");

endmodule
